[design/mrhs_pkg.sv]
package mrhs_pkg;

  localparam int unsigned FLEN_W = 9;

  localparam logic [1:0] KIND_RX    = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_TXRDY = 2'd2;

  localparam logic [7:0] FN_READ  = 8'h03;
  localparam logic [7:0] FN_WRITE = 8'h06;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_CRC      = 3'd1;
  localparam logic [2:0] ST_ADDR     = 3'd2;
  localparam logic [2:0] ST_FUNC     = 3'd3;
  localparam logic [2:0] ST_RANGE    = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;
  localparam logic [2:0] ST_BUSY     = 3'd6;

  localparam logic [2:0] SEL_CONST  = 3'd0;
  localparam logic [2:0] SEL_MEM_HI = 3'd1;
  localparam logic [2:0] SEL_MEM_LO = 3'd2;
  localparam logic [2:0] SEL_CRC_LO = 3'd3;
  localparam logic [2:0] SEL_CRC_HI = 3'd4;

  typedef struct packed {
    logic       rtype;
    logic [2:0] sel;
    logic [7:0] data;
    logic       last;
    logic [2:0] status;
    logic       crc_upd;
  } op_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ 16'hA001;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[design/mrhs_regfile.sv]
module mrhs_regfile #(
  parameter int unsigned REG_COUNT = 64,
  parameter int unsigned AW = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o
);

  logic [15:0]          mem_q [REG_COUNT];
  logic [REG_COUNT-1:0] vld_q;
  logic [15:0]          rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= vld_q[raddr_i] ? mem_q[raddr_i] : 16'h0000;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/mrhs_front.sv]
module mrhs_front import mrhs_pkg::*; #(
  parameter int unsigned REG_COUNT = 64,
  parameter int unsigned AW = 6,
  parameter int unsigned MAX_FRAME = 250,
  parameter int unsigned MAX_READ_REGS = 125
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_index_i,
  input  logic [15:0]   cfg_data_i,
  input  logic          accept_i,
  input  logic [1:0]    kind_i,
  input  logic [7:0]    rx_byte_i,
  output logic          op_valid_o,
  output op_t           op_o,
  output logic          we_o,
  output logic [AW-1:0] waddr_o,
  output logic [15:0]   wdata_o,
  output logic          re_o,
  output logic [AW-1:0] raddr_o
);

  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_IDLE = 2'd1;
  localparam logic [1:0] PH_RECV = 2'd2;

  logic [7:0]        addr_q;
  logic [15:0]       lim_q;
  logic [1:0]        phase_q, phase_d;
  logic [15:0]       sil_q, sil_d;
  logic [FLEN_W-1:0] flen_q, flen_d;
  logic [7:0]        req_q [6];
  logic [15:0]       rcrc_q, rcrc_d;
  logic              busy_q, busy_d;
  logic              tact_q, tact_d;
  logic [7:0]        tidx_q, tidx_d;
  logic [7:0]        tlen_q, tlen_d;
  logic              req_we;
  logic [2:0]        req_wa;

  logic [15:0] limit, sil_inc, start, count, rd_off;
  logic [16:0] rd_end;
  logic        bcast;
  logic [2:0]  fe_status;
  logic        fe_write, fe_tx;
  logic [7:0]  fe_len;

  assign limit = (lim_q == 16'd0) ? 16'd1 : lim_q;
  assign sil_inc = (sil_q == 16'hFFFF) ? sil_q : sil_q + 16'd1;
  assign start = {req_q[2], req_q[3]};
  assign count = {req_q[4], req_q[5]};
  assign rd_end = {1'b0, start} + {1'b0, count};
  assign bcast = (req_q[0] == 8'h00);
  assign rd_off = ({8'h00, tidx_q} - 16'd3) >> 1;

  always_comb begin
    fe_status = ST_OK;
    fe_write  = 1'b0;
    fe_tx     = 1'b0;
    fe_len    = 8'd8;
    if (rcrc_q != 16'h0000) begin
      fe_status = ST_CRC;
    end else if (busy_q || tact_q) begin
      fe_status = ST_BUSY;
    end else if (req_q[0] != addr_q && !bcast) begin
      fe_status = ST_ADDR;
    end else if (flen_q != FLEN_W'(8)) begin
      fe_status = ST_FUNC;
    end else if (req_q[1] == FN_READ) begin
      if (count == 16'd0 || count > 16'(MAX_READ_REGS) || rd_end > 17'(REG_COUNT)) begin
        fe_status = ST_RANGE;
      end else begin
        fe_tx  = !bcast;
        fe_len = 8'd5 + {count[6:0], 1'b0};
      end
    end else if (req_q[1] == FN_WRITE) begin
      if ({1'b0, start} >= 17'(REG_COUNT)) begin
        fe_status = ST_RANGE;
      end else begin
        fe_write = 1'b1;
        fe_tx    = !bcast;
      end
    end else begin
      fe_status = ST_FUNC;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    sil_d      = sil_q;
    flen_d     = flen_q;
    rcrc_d     = rcrc_q;
    busy_d     = busy_q;
    tact_d     = tact_q;
    tidx_d     = tidx_q;
    tlen_d     = tlen_q;
    req_we     = 1'b0;
    req_wa     = flen_q[2:0];
    op_valid_o = 1'b0;
    op_o       = '{rtype: 1'b1, sel: SEL_CONST, data: 8'h00, last: 1'b0,
                   status: ST_OK, crc_upd: 1'b0};
    we_o       = 1'b0;
    re_o       = 1'b0;
    raddr_o    = AW'(start + rd_off);
    if (accept_i) begin
      if (kind_i == KIND_RX) begin
        sil_d = 16'd0;
        if (phase_q == PH_IDLE || phase_q == PH_RECV) begin
          if (phase_q == PH_IDLE) begin
            phase_d = PH_RECV;
          end
          if (phase_q == PH_RECV && flen_q >= FLEN_W'(MAX_FRAME)) begin
            phase_d    = PH_WAIT;
            op_valid_o = 1'b1;
            op_o.status = ST_OVERFLOW;
          end else begin
            if (tact_q) begin
              busy_d = 1'b1;
            end else begin
              busy_d = (phase_q == PH_IDLE) ? 1'b0 : busy_q;
              req_we = (phase_q == PH_IDLE) || (flen_q < FLEN_W'(6));
            end
            if (phase_q == PH_IDLE) begin
              req_wa = 3'd0;
              flen_d = FLEN_W'(1);
              rcrc_d = crc_step(16'hFFFF, rx_byte_i);
            end else begin
              flen_d = flen_q + FLEN_W'(1);
              rcrc_d = crc_step(rcrc_q, rx_byte_i);
            end
          end
        end
      end else if (kind_i == KIND_TICK) begin
        if (phase_q != PH_IDLE) begin
          if (sil_inc < limit) begin
            sil_d = sil_inc;
          end else begin
            sil_d   = 16'd0;
            phase_d = PH_IDLE;
            if (phase_q == PH_RECV) begin
              op_valid_o  = 1'b1;
              op_o.status = fe_status;
              we_o        = fe_write;
              if (fe_tx) begin
                tact_d = 1'b1;
                tidx_d = 8'd0;
                tlen_d = fe_len;
              end
            end
          end
        end
      end else if (kind_i == KIND_TXRDY && tact_q) begin
        op_valid_o = 1'b1;
        op_o.rtype = 1'b0;
        tidx_d     = tidx_q + 8'd1;
        if ({1'b0, tidx_q} + 9'd2 == {1'b0, tlen_q}) begin
          op_o.sel = SEL_CRC_LO;
        end else if ({1'b0, tidx_q} + 9'd1 >= {1'b0, tlen_q}) begin
          op_o.sel  = SEL_CRC_HI;
          op_o.last = 1'b1;
          tact_d    = 1'b0;
          tidx_d    = 8'd0;
        end else begin
          op_o.crc_upd = 1'b1;
          if (req_q[1] == FN_WRITE) begin
            op_o.data = (tidx_q < 8'd6) ? req_q[tidx_q[2:0]] : 8'h00;
          end else if (tidx_q == 8'd0) begin
            op_o.data = req_q[0];
          end else if (tidx_q == 8'd1) begin
            op_o.data = FN_READ;
          end else if (tidx_q == 8'd2) begin
            op_o.data = tlen_q - 8'd5;
          end else begin
            re_o     = 1'b1;
            op_o.sel = tidx_q[0] ? SEL_MEM_HI : SEL_MEM_LO;
          end
        end
      end
    end
  end

  assign waddr_o = AW'(start);
  assign wdata_o = count;

  always_ff @(posedge clk_i) begin
    if (req_we) begin
      req_q[req_wa] <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q  <= 8'd1;
      lim_q   <= 16'd40320;
      phase_q <= PH_WAIT;
      sil_q   <= 16'd0;
      flen_q  <= '0;
      rcrc_q  <= 16'hFFFF;
      busy_q  <= 1'b0;
      tact_q  <= 1'b0;
      tidx_q  <= 8'd0;
      tlen_q  <= 8'd0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i) begin
          lim_q <= cfg_data_i;
        end else begin
          addr_q <= cfg_data_i[7:0];
        end
      end
      phase_q <= phase_d;
      sil_q   <= sil_d;
      flen_q  <= flen_d;
      rcrc_q  <= rcrc_d;
      busy_q  <= busy_d;
      tact_q  <= tact_d;
      tidx_q  <= tidx_d;
      tlen_q  <= tlen_d;
    end
  end

endmodule

[design/mrhs_back.sv]
module mrhs_back import mrhs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        op_valid_i,
  input  op_t         op_i,
  input  logic [15:0] rdata_i,
  output logic        busy_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_type_o,
  output logic [7:0]  tx_byte_o,
  output logic        tx_last_o,
  output logic [2:0]  frame_status_o
);

  logic        s1_valid_q, s1_valid_d;
  op_t         s1_q;
  logic [15:0] crc_q, crc_d;
  logic        out_valid_q, out_valid_d;
  logic        rtype_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic [2:0]  status_q;
  logic        adv;
  logic [7:0]  val;

  assign adv    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign busy_o = s1_valid_q && !adv;

  always_comb begin
    case (s1_q.sel)
      SEL_MEM_HI: val = rdata_i[15:8];
      SEL_MEM_LO: val = rdata_i[7:0];
      SEL_CRC_LO: val = crc_q[7:0];
      SEL_CRC_HI: val = crc_q[15:8];
      default:    val = s1_q.data;
    endcase
  end

  always_comb begin
    crc_d = crc_q;
    if (adv) begin
      if (s1_q.crc_upd) begin
        crc_d = crc_step(crc_q, val);
      end else if (s1_q.last) begin
        crc_d = 16'hFFFF;
      end
    end
    s1_valid_d  = op_valid_i ? 1'b1 : (adv ? 1'b0 : s1_valid_q);
    out_valid_d = adv ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  end

  always_ff @(posedge clk_i) begin
    if (op_valid_i) begin
      s1_q <= op_i;
    end
    if (adv) begin
      rtype_q  <= s1_q.rtype;
      byte_q   <= val;
      last_q   <= s1_q.last;
      status_q <= s1_q.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      crc_q       <= 16'hFFFF;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      crc_q       <= crc_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_type_o  = rtype_q;
  assign tx_byte_o      = byte_q;
  assign tx_last_o      = last_q;
  assign frame_status_o = status_q;

endmodule

[design/modbus_rtu_holding_register_slave_top.sv]
// Modbus RTU slave serving holding registers through functions 03 and 06.
// The input channel carries one event per request: a received byte, a timer
// tick or a transmitter-ready event. The output channel carries either a
// response byte or a frame outcome report; a request produces at most one.
// A request is accepted while in_stall_o is low, and requests may then follow back to back.
// A result passes through the back stage register and then the output register.
// The front stage updates the receive state and issues a register read, the
// back stage picks the byte from the registered-read register memory and folds it
// into the transmit checksum, and an output register holds the result.
// When the receiver stalls, the output register holds its result, the back
// stage fills, and then in_stall_o is raised until the output drains.
// Configuration writes take effect at the next clock edge.
// Reset clears all control state, sets the station address to 1 and the
// silence limit to 40320 ticks, and makes all holding registers read zero
// at once through per-entry valid bits. The block then waits for one period
// of line silence before it accepts a frame.
module modbus_rtu_holding_register_slave_top import mrhs_pkg::*; #(
  parameter int unsigned REG_COUNT = 64,
  parameter int unsigned MAX_FRAME = 250,
  parameter int unsigned MAX_READ_REGS = 125
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_type_o,
  output logic [7:0]  tx_byte_o,
  output logic        tx_last_o,
  output logic [2:0]  frame_status_o
);

  localparam int unsigned AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  logic          accept;
  logic          op_valid;
  op_t           op;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata, rdata;
  logic          back_busy;

  assign in_stall_o = back_busy;
  assign accept     = in_valid_i && !back_busy;

  mrhs_front #(
    .REG_COUNT(REG_COUNT),
    .AW(AW),
    .MAX_FRAME(MAX_FRAME),
    .MAX_READ_REGS(MAX_READ_REGS)
  ) u_front (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .accept_i(accept),
    .kind_i(kind_i),
    .rx_byte_i(rx_byte_i),
    .op_valid_o(op_valid),
    .op_o(op),
    .we_o(we),
    .waddr_o(waddr),
    .wdata_o(wdata),
    .re_o(re),
    .raddr_o(raddr)
  );

  mrhs_regfile #(
    .REG_COUNT(REG_COUNT),
    .AW(AW)
  ) u_regfile (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .we_i(we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i(re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  mrhs_back u_back (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .op_valid_i(op_valid),
    .op_i(op),
    .rdata_i(rdata),
    .busy_o(back_busy),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .result_type_o(result_type_o),
    .tx_byte_o(tx_byte_o),
    .tx_last_o(tx_last_o),
    .frame_status_o(frame_status_o)
  );

endmodule

[verif/tb_modbus_rtu_holding_register_slave_top.sv]
`timescale 1ns / 1ps

class slave_scoreboard;
  typedef struct packed {
    logic       rtype;
    logic [7:0] data;
    logic       last;
    logic [2:0] status;
  } outcome_t;

  localparam int NREGS = 64;
  localparam int MAXLEN = 250;
  localparam int MAXRD = 125;
  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_IDLE = 2'd1;
  localparam logic [1:0] PH_RECV = 2'd2;

  logic [7:0]  own_addr;
  logic [15:0] quiet_limit;
  logic [1:0]  phase;
  logic [15:0] quiet_cnt;
  int unsigned flen;
  logic [7:0]  head [6];
  logic [15:0] rx_crc;
  logic [15:0] regs [NREGS];
  bit          sending;
  logic [7:0]  tx_idx;
  logic [7:0]  tx_len;
  logic [15:0] tx_crc;
  bit          busy_frame;
  outcome_t    pending [$];
  int          mismatches;
  int          checked;
  int          frames_ok;
  int          tx_bytes;

  function new();
    own_addr = 8'd1;
    quiet_limit = 16'd40320;
    phase = PH_WAIT;
    quiet_cnt = '0;
    flen = 0;
    foreach (head[i]) head[i] = '0;
    rx_crc = 16'hFFFF;
    foreach (regs[i]) regs[i] = '0;
    sending = 0;
    tx_idx = '0;
    tx_len = '0;
    tx_crc = 16'hFFFF;
    busy_frame = 0;
    mismatches = 0;
    checked = 0;
    frames_ok = 0;
    tx_bytes = 0;
  endfunction

  function logic [15:0] crc_fold(logic [15:0] c, logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  function void set_reg(bit idx, logic [15:0] v);
    if (idx == 1'b0) own_addr = v[7:0];
    else quiet_limit = v;
  endfunction

  function logic [2:0] close_frame();
    int unsigned first, cnt;
    bit bcast;
    if (rx_crc != 0) return mrhs_pkg::ST_CRC;
    if (busy_frame || sending) return mrhs_pkg::ST_BUSY;
    if (head[0] != own_addr && head[0] != 0) return mrhs_pkg::ST_ADDR;
    bcast = (head[0] == 0);
    if (flen != 8) return mrhs_pkg::ST_FUNC;
    first = {head[2], head[3]};
    cnt = {head[4], head[5]};
    if (head[1] == mrhs_pkg::FN_READ) begin
      if (cnt < 1 || cnt > MAXRD || first + cnt > NREGS) return mrhs_pkg::ST_RANGE;
      if (!bcast) begin
        sending = 1; tx_idx = 8'd0; tx_len = 8'(5 + 2 * cnt); tx_crc = 16'hFFFF;
      end
      return mrhs_pkg::ST_OK;
    end
    if (head[1] == mrhs_pkg::FN_WRITE) begin
      if (first >= NREGS) return mrhs_pkg::ST_RANGE;
      regs[first] = 16'(cnt);
      if (!bcast) begin
        sending = 1; tx_idx = 8'd0; tx_len = 8'd8; tx_crc = 16'hFFFF;
      end
      return mrhs_pkg::ST_OK;
    end
    return mrhs_pkg::ST_FUNC;
  endfunction

  function logic [7:0] reply_byte(logic [7:0] i);
    int unsigned r;
    if (head[1] == mrhs_pkg::FN_WRITE) return (i < 6) ? head[i] : 8'h00;
    if (i == 0) return head[0];
    if (i == 1) return mrhs_pkg::FN_READ;
    if (i == 2) return tx_len - 8'd5;
    r = {head[2], head[3]} + (i - 3) / 2;
    if (r >= NREGS) return 8'h00;
    return ((i - 3) % 2 == 0) ? regs[r][15:8] : regs[r][7:0];
  endfunction

  function void note_request(logic [1:0] kind, logic [7:0] b);
    outcome_t o;
    logic [15:0] lim;
    logic [2:0] st;
    logic [7:0] v;
    bit last;
    lim = (quiet_limit == 0) ? 16'd1 : quiet_limit;
    o = '0;
    if (kind == mrhs_pkg::KIND_RX) begin
      if (phase == PH_IDLE) begin
        flen = 0; rx_crc = 16'hFFFF; busy_frame = 0; phase = PH_RECV;
      end else if (phase != PH_RECV) begin
        quiet_cnt = 16'd0;
        return;
      end
      quiet_cnt = 16'd0;
      if (flen >= MAXLEN) begin
        phase = PH_WAIT;
        o.rtype = 1; o.status = mrhs_pkg::ST_OVERFLOW;
        pending.push_back(o);
        return;
      end
      if (sending) busy_frame = 1;
      else if (flen < 6) head[flen] = b;
      flen++;
      rx_crc = crc_fold(rx_crc, b);
    end else if (kind == mrhs_pkg::KIND_TICK) begin
      if (phase == PH_IDLE) return;
      if (quiet_cnt != 16'hFFFF) quiet_cnt++;
      if (quiet_cnt < lim) return;
      quiet_cnt = 16'd0;
      if (phase == PH_RECV) begin
        phase = PH_IDLE;
        st = close_frame();
        if (st == mrhs_pkg::ST_OK) frames_ok++;
        o.rtype = 1; o.status = st;
        pending.push_back(o);
        return;
      end
      phase = PH_IDLE;
    end else if (kind == mrhs_pkg::KIND_TXRDY && sending) begin
      last = 0;
      if (tx_idx + 2 == tx_len) v = tx_crc[7:0];
      else if (tx_idx + 1 >= tx_len) begin
        v = tx_crc[15:8]; last = 1;
      end else begin
        v = reply_byte(tx_idx); tx_crc = crc_fold(tx_crc, v);
      end
      if (last) begin
        sending = 0; tx_idx = 8'd0;
      end else tx_idx = tx_idx + 8'd1;
      o.data = v; o.last = last;
      pending.push_back(o);
    end
  endfunction

  function void check_result(outcome_t got);
    outcome_t exp;
    checked++;
    if (got.rtype == 0) tx_bytes++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %p", got);
      return;
    end
    exp = pending.pop_front();
    if (got !== exp) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"mismatch: expected type %0d byte %02h last %0d status %0d, ",
                  "got type %0d byte %02h last %0d status %0d"},
                 exp.rtype, exp.data, exp.last, exp.status,
                 got.rtype, got.data, got.last, got.status);
    end
  endfunction
endclass

module tb_modbus_rtu_holding_register_slave_top;
  import mrhs_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic        cfg_index_i = 0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [1:0]  kind_i = '0;
  logic [7:0]  rx_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic        result_type_o;
  logic [7:0]  tx_byte_o;
  logic        tx_last_o;
  logic [2:0]  frame_status_o;

  slave_scoreboard sb = new();
  int requests_sent = 0;
  bit quiet_gaps = 0;
  logic [15:0] cur_quiet = 16'd40320;

  modbus_rtu_holding_register_slave_top dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  function automatic int gap_len();
    int r;
    if (quiet_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result({result_type_o, tx_byte_o, tx_last_o, frame_status_o});
  end

  always @(negedge clk_i) begin
    out_stall_i <= quiet_gaps ? 1'b0 : (gap_len() != 0);
  end

  task automatic send(logic [1:0] kind, logic [7:0] b);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1;
    kind_i <= kind;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(kind, b);
    requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic silence();
    for (int i = 0; i < int'(cur_quiet == 0 ? 16'd1 : cur_quiet); i++) send(KIND_TICK, 8'h00);
  endtask

  task automatic drain_tx();
    while (sb.sending) send(KIND_TXRDY, 8'($urandom_range(0, 255)));
  endtask

  task automatic frame(logic [7:0] bytes [$], bit good_crc);
    logic [15:0] c;
    c = 16'hFFFF;
    foreach (bytes[i]) c = sb.crc_fold(c, bytes[i]);
    if (good_crc) begin
      bytes.push_back(c[7:0]);
      bytes.push_back(c[15:8]);
    end
    foreach (bytes[i]) send(KIND_RX, bytes[i]);
    silence();
  endtask

  task automatic cmd(logic [7:0] a, logic [7:0] fn, logic [15:0] p, logic [15:0] q);
    logic [7:0] b [$];
    b = {a, fn, p[15:8], p[7:0], q[15:8], q[7:0]};
    frame(b, 1);
    drain_tx();
  endtask

  task automatic idle_wait();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_cfg(bit idx, logic [15:0] v);
    idle_wait();
    cfg_we_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 0;
    sb.set_reg(idx, v);
    if (idx) cur_quiet = v;
  endtask

  task automatic random_frame();
    int r;
    logic [7:0] a, fn;
    logic [15:0] p, q;
    logic [7:0] b [$];
    r = $urandom_range(0, 99);
    a = ($urandom_range(0, 9) == 0) ? 8'h00 :
        ($urandom_range(0, 9) == 0) ? 8'($urandom) : sb.own_addr;
    if (r < 40) begin
      p = 16'($urandom_range(0, 70));
      q = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 10));
      cmd(a, FN_READ, p, q);
    end else if (r < 75) begin
      p = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 63));
      cmd(a, FN_WRITE, p, 16'($urandom));
    end else if (r < 85) begin
      b = {a, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
      frame(b, 1'($urandom_range(0, 1)));
      drain_tx();
    end else if (r < 92) begin
      b = {};
      repeat ($urandom_range(1, 12)) b.push_back(8'($urandom));
      frame(b, 1'($urandom_range(0, 1)));
      drain_tx();
    end else begin
      cmd(sb.own_addr, FN_READ, 16'($urandom_range(0, 3)), 16'($urandom_range(1, 6)));
      b = {sb.own_addr, FN_WRITE, 8'h00, 8'h01, 8'($urandom), 8'($urandom)};
      repeat ($urandom_range(0, 3)) send(KIND_TXRDY, 8'h00);
      frame(b, 1);
      drain_tx();
    end
  endtask

  initial begin
    logic [7:0] b [$];
    repeat (12) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    write_cfg(1'b1, 16'd4);
    write_cfg(1'b0, 16'd1);
    send(KIND_TXRDY, 8'h00);
    send(KIND_RX, 8'hFF);
    silence();
    silence();
    cmd(8'h01, FN_WRITE, 16'd0, 16'hFFFF);
    cmd(8'h01, FN_WRITE, 16'd63, 16'hA55A);
    cmd(8'h01, FN_READ, 16'd0, 16'd1);
    cmd(8'h01, FN_READ, 16'd62, 16'd2);
    cmd(8'h01, FN_READ, 16'd0, 16'd0);
    cmd(8'h01, FN_READ, 16'd0, 16'd126);
    cmd(8'h01, FN_READ, 16'hFFFF, 16'hFFFF);
    cmd(8'h01, FN_WRITE, 16'd64, 16'd1);
    cmd(8'h00, FN_WRITE, 16'd5, 16'h1234);
    cmd(8'h00, FN_READ, 16'd5, 16'd1);
    cmd(8'h07, FN_READ, 16'd5, 16'd1);
    cmd(8'h01, 8'h16, 16'd5, 16'd1);
    b = {8'h01, FN_READ, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00};
    frame(b, 0);
    b = {8'h01, FN_READ, 8'h00};
    frame(b, 1);
    send(KIND_RX, 8'h01);
    for (int i = 0; i < 250; i++) send(KIND_RX, 8'h80 >> (i % 8));
    send(KIND_RX, 8'h7F);
    silence();
    send(2'd3, 8'h00);
    write_cfg(1'b1, 16'd0);
    write_cfg(1'b0, 16'd247);
    cmd(8'd247, FN_READ, 16'd0, 16'd3);
    write_cfg(1'b0, 16'd255);
    cmd(8'd255, FN_WRITE, 16'd7, 16'h0F0F);
    write_cfg(1'b1, 16'd2);
    write_cfg(1'b0, 16'd0);
    cmd(8'd0, FN_WRITE, 16'd8, 16'd1);
    write_cfg(1'b0, 16'd1);
    cmd(8'h01, FN_READ, 16'd0, 16'd64);
    write_cfg(1'b1, 16'd3);
    for (int n = 0; requests_sent < 1000 && n < 200; n++) begin
      quiet_gaps = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) == 0) send(2'($urandom), 8'($urandom));
      random_frame();
      if (n == 10) begin
        write_cfg(1'b0, 16'd9);
        write_cfg(1'b1, 16'd1);
      end
    end
    quiet_gaps = 0;
    idle_wait();
    write_cfg(1'b1, 16'hFFFF);
    send(KIND_TICK, 8'h00);
    idle_wait();
    $display("Sent %0d requests; %0d results checked, %0d frames accepted, %0d reply bytes.",
             requests_sent, sb.checked, sb.frames_ok, sb.tx_bytes);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb_modbus_rtu_holding_register_slave_top OK");
    end else begin
      $display("Mismatches: %0d, outstanding: %0d", sb.mismatches, sb.pending.size());
      $display("tb_modbus_rtu_holding_register_slave_top NOT OK");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_modbus_rtu_holding_register_slave_top NOT OK");
    $finish;
  end
endmodule
